// ===== hw/rtl/sscc_pkg.sv =====
// Shared widths, field positions, codes and helpers for the SSD crop candidate check.
package sscc_pkg;

    // Geometry and counting
    localparam int COORD_W   = 17;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int UNI_W     = PROD_W + 2;
    localparam int CMP_W     = UNI_W + 4;
    localparam int OPT_W     = 3;
    localparam int MAX_BOXES = 256;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    // Input tdata layout, lowest field first
    localparam int CROP_L_LSB      = 0;
    localparam int CROP_T_LSB      = CROP_L_LSB + COORD_W;
    localparam int CROP_R_LSB      = CROP_T_LSB + COORD_W;
    localparam int CROP_B_LSB      = CROP_R_LSB + COORD_W;
    localparam int OPTION_LSB      = CROP_B_LSB + COORD_W;
    localparam int BOX_LEFT_LSB    = OPTION_LSB + OPT_W;
    localparam int BOX_TOP_LSB     = BOX_LEFT_LSB + COORD_W;
    localparam int BOX_RIGHT_LSB   = BOX_TOP_LSB + COORD_W;
    localparam int BOX_BOTTOM_LSB  = BOX_RIGHT_LSB + COORD_W;
    localparam int S_FIELDS_W      = BOX_BOTTOM_LSB + COORD_W;
    localparam int S_TDATA_W       = ((S_FIELDS_W + 7) / 8) * 8;

    // Result tdata layout, lowest field first
    localparam int M_FIELDS_W = 4 + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_ALL_OVERLAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_GIVEN       = 1'd1;

    // Option codes
    localparam logic [OPT_W-1:0] OPT_TH_FIRST = 3'd1;
    localparam logic [OPT_W-1:0] OPT_TH_LAST  = 3'd5;
    localparam logic [OPT_W-1:0] OPT_IOU_0P1  = 3'd1;
    localparam logic [OPT_W-1:0] OPT_IOU_0P3  = 3'd2;
    localparam logic [OPT_W-1:0] OPT_IOU_0P5  = 3'd3;
    localparam logic [OPT_W-1:0] OPT_IOU_0P7  = 3'd4;
    localparam logic [OPT_W-1:0] OPT_IOU_0P9  = 3'd5;
    localparam logic [OPT_W-1:0] OPT_WHOLE    = 3'd6;

    // Threshold tenths times the union, built from shifts, adds and a subtraction
    function automatic logic signed [CMP_W-1:0] tenths_times(
        input logic [OPT_W-1:0]       opt,
        input logic signed [UNI_W-1:0] uni
    );
        logic signed [CMP_W-1:0] u;
        logic signed [CMP_W-1:0] r;
        u = CMP_W'(uni);
        case (opt)
            OPT_IOU_0P1: r = u;
            OPT_IOU_0P3: r = (u <<< 1) + u;
            OPT_IOU_0P5: r = (u <<< 2) + u;
            OPT_IOU_0P7: r = (u <<< 3) - u;
            OPT_IOU_0P9: r = (u <<< 3) + u;
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/ssd_crop_candidate_check.sv =====
// SSD crop candidate check: per-box IoU threshold and center test, verdict on the last box.
// Each box item is accepted in idle, then intersection, box area and crop area take turns on
// one shared 18x18 signed multiplier, then union and decision; a new item is taken only in idle.
// A verdict is registered onto m_tvalid from the decision step of the last box; while it waits the
// input stays ready in idle, and a further last box holds in its decision step until taken.
// Synchronous active-low reset clears the sequencer, output valid, configuration registers and accumulators.
module ssd_crop_candidate_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // crop left, crop top, crop right, crop bottom, option index,
    // box left, box top, box right, box bottom, zero fill
    input  logic [sscc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,   // first_box
    input  logic                          s_tlast,   // last_box
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accept, whole_image, aspect_bad, overlap_bad, centres_inside, zero fill
    output logic [sscc_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sscc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data
);
    import sscc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_MUL_INTER = 6'b000010,
        ST_MUL_BOX   = 6'b000100,
        ST_MUL_CROP  = 6'b001000,
        ST_UNION     = 6'b010000,
        ST_DECIDE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic check_all_reg;
    logic shape_given_reg;
    logic overlap_failed_reg;
    logic [CNT_W-1:0] centre_count_reg;

    // Item payload held for the sequencer
    logic [COORD_W-1:0] cl_reg, ct_reg, cr_reg, cb_reg;
    logic [COORD_W-1:0] bl_reg, bt_reg, br_reg, bb_reg;
    logic [OPT_W-1:0]   opt_reg;
    logic               last_reg;

    // Shared multiplier and intermediate results
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_reg, inter_reg, abox_reg;
    logic signed [UNI_W-1:0]  uni_reg;

    logic s_accept;
    logic out_blocked;

    assign cfg_ready   = 1'b1;
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign out_blocked = last_reg && m_tvalid && !m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_all_reg   <= 1'b0;
            shape_given_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CHECK_ALL_OVERLAP: check_all_reg   <= cfg_data;
                REG_SHAPE_GIVEN:       shape_given_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Intersection extents, clamped at zero
    logic [COORD_W-1:0]       ix_lo, ix_hi, iy_lo, iy_hi;
    logic signed [DIFF_W-1:0] iw_raw, ih_raw, iw, ih;
    always_comb begin
        ix_lo  = (bl_reg > cl_reg) ? bl_reg : cl_reg;
        ix_hi  = (br_reg < cr_reg) ? br_reg : cr_reg;
        iy_lo  = (bt_reg > ct_reg) ? bt_reg : ct_reg;
        iy_hi  = (bb_reg < cb_reg) ? bb_reg : cb_reg;
        iw_raw = $signed({1'b0, ix_hi}) - $signed({1'b0, ix_lo});
        ih_raw = $signed({1'b0, iy_hi}) - $signed({1'b0, iy_lo});
        iw     = iw_raw[DIFF_W-1] ? '0 : iw_raw;
        ih     = ih_raw[DIFF_W-1] ? '0 : ih_raw;
    end

    // Select multiplier operands by step
    always_comb begin
        case (state_reg)
            ST_MUL_INTER: begin
                mul_a = iw;
                mul_b = ih;
            end
            ST_MUL_BOX: begin
                mul_a = $signed({1'b0, bb_reg}) - $signed({1'b0, bt_reg});
                mul_b = $signed({1'b0, br_reg}) - $signed({1'b0, bl_reg});
            end
            default: begin
                mul_a = $signed({1'b0, cb_reg}) - $signed({1'b0, ct_reg});
                mul_b = $signed({1'b0, cr_reg}) - $signed({1'b0, cl_reg});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Threshold decision, center test and aspect test
    logic                     thr_on, box_fail, centre_in, aspect_bad, whole;
    logic signed [CMP_W-1:0]  ten_inter, k_uni;
    logic [DIFF_W-1:0]        xc2, yc2;
    logic signed [DIFF_W:0]   crop_w, crop_h;
    logic                     ovl_failed_next, ovl_bad;
    logic [CNT_W-1:0]         count_next;
    always_comb begin
        thr_on    = check_all_reg && (opt_reg inside {[OPT_TH_FIRST:OPT_TH_LAST]});
        ten_inter = (CMP_W'(inter_reg) <<< 3) + (CMP_W'(inter_reg) <<< 1);
        k_uni     = tenths_times(opt_reg, uni_reg);
        box_fail  = (uni_reg < 0) || ((uni_reg > 0) && (ten_inter < k_uni));
        ovl_failed_next = overlap_failed_reg || (thr_on && box_fail);

        xc2 = {1'b0, bl_reg} + {1'b0, br_reg};
        yc2 = {1'b0, bt_reg} + {1'b0, bb_reg};
        centre_in = (xc2 > {cl_reg, 1'b0}) && (xc2 < {cr_reg, 1'b0})
                 && (yc2 > {ct_reg, 1'b0}) && (yc2 < {cb_reg, 1'b0});
        count_next = centre_count_reg;
        if (centre_in && (centre_count_reg < CNT_W'(MAX_BOXES)))
            count_next = centre_count_reg + 1'b1;

        crop_w = $signed({2'b00, cr_reg}) - $signed({2'b00, cl_reg});
        crop_h = $signed({2'b00, cb_reg}) - $signed({2'b00, ct_reg});
        aspect_bad = (crop_w <= 0) || (crop_h <= 0)
                  || ((crop_w <<< 1) < crop_h) || (crop_w > (crop_h <<< 1));
        ovl_bad = check_all_reg && ovl_failed_next;
        whole   = (opt_reg >= OPT_WHOLE) || shape_given_reg;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_accept) state_next = ST_MUL_INTER;
            ST_MUL_INTER: state_next = ST_MUL_BOX;
            ST_MUL_BOX:   state_next = ST_MUL_CROP;
            ST_MUL_CROP:  state_next = ST_UNION;
            ST_UNION:     state_next = ST_DECIDE;
            ST_DECIDE:    if (!out_blocked) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cl_reg   <= s_tdata[CROP_L_LSB      +: COORD_W];
            ct_reg   <= s_tdata[CROP_T_LSB      +: COORD_W];
            cr_reg   <= s_tdata[CROP_R_LSB      +: COORD_W];
            cb_reg   <= s_tdata[CROP_B_LSB      +: COORD_W];
            opt_reg  <= s_tdata[OPTION_LSB      +: OPT_W];
            bl_reg   <= s_tdata[BOX_LEFT_LSB    +: COORD_W];
            bt_reg   <= s_tdata[BOX_TOP_LSB     +: COORD_W];
            br_reg   <= s_tdata[BOX_RIGHT_LSB   +: COORD_W];
            bb_reg   <= s_tdata[BOX_BOTTOM_LSB  +: COORD_W];
            last_reg <= s_tlast;
        end
    end

    // Advance the arithmetic through the shared multiplier
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_MUL_INTER: prod_reg <= mul_p;
            ST_MUL_BOX: begin
                inter_reg <= prod_reg;
                prod_reg  <= mul_p;
            end
            ST_MUL_CROP: begin
                abox_reg <= prod_reg;
                prod_reg <= mul_p;
            end
            ST_UNION: uni_reg <= UNI_W'(abox_reg) + UNI_W'(prod_reg) - UNI_W'(inter_reg);
            default: ;
        endcase
    end

    // Accumulators: clear on a first box, update once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlap_failed_reg <= 1'b0;
            centre_count_reg   <= '0;
        end else if (s_accept && s_tuser) begin
            overlap_failed_reg <= 1'b0;
            centre_count_reg   <= '0;
        end else if ((state_reg == ST_DECIDE) && !out_blocked) begin
            overlap_failed_reg <= ovl_failed_next;
            centre_count_reg   <= count_next;
        end
    end

    // Pack the verdict item
    logic [M_TDATA_W-1:0] verdict_word;
    always_comb begin
        verdict_word = '0;
        if (whole) begin
            verdict_word[0] = 1'b1;
            verdict_word[1] = 1'b1;
        end else begin
            verdict_word[0] = !aspect_bad && !ovl_bad && (count_next != '0);
            verdict_word[2] = aspect_bad;
            verdict_word[3] = ovl_bad;
            verdict_word[4 +: CNT_W] = count_next;
        end
    end

    // Output register: load the verdict, drop valid once taken
    logic m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == ST_DECIDE) && last_reg && !out_blocked) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DECIDE) && last_reg && !out_blocked) begin
            m_tdata_reg <= verdict_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SSD crop candidate check: directed images, then random phases.
module tb_top;

    import sscc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int ONE          = 1 << 16;
    localparam int SETTLE       = 24;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_PCT     = 81;
    localparam int BOTH_PCT     = 11;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_PRINTS   = 200;
    localparam int CROWD_BOXES  = 260;

    // Option 7 also selects the whole image
    localparam logic [OPT_W-1:0] OPT_WHOLE_ALT = 3'd7;
    localparam logic [OPT_W-1:0] OPT_NONE      = 3'd0;

    typedef struct {
        logic [COORD_W-1:0] cl, ct, cr, cb;
        logic [OPT_W-1:0]   opt;
        logic [COORD_W-1:0] bl, bt, br, bb;
        bit                 first;
        bit                 last;
    } box_item_t;

    typedef struct {
        bit               accept;
        bit               whole;
        bit               aspect_bad;
        bit               overlap_bad;
        logic [CNT_W-1:0] centres;
    } verdict_t;

    // Running crop verdict prediction and the queue of verdicts still owed
    class crop_verdict_board;
        bit       check_overlap;
        bit       shape_forced;
        bit       overlap_failed;
        int       centre_count;
        int       errors;
        verdict_t expected_verdicts[$];

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
            if (idx == REG_CHECK_ALL_OVERLAP) begin
                check_overlap = val;
            end else if (idx == REG_SHAPE_GIVEN) begin
                shape_forced = val;
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("ERROR: %s", msg);
            end
        endtask

        // Fold one accepted box into the running state; queue a verdict on the last box
        function void predict_box(box_item_t it);
            longint cl, ct, cr, cb, bl, bt, br, bb;
            longint iw, ih, inter, area_box, area_crop, uni, k, w, h;
            verdict_t v;
            cl = it.cl; ct = it.ct; cr = it.cr; cb = it.cb;
            bl = it.bl; bt = it.bt; br = it.br; bb = it.bb;
            if (it.first) begin
                overlap_failed = 0;
                centre_count = 0;
            end
            // IoU below threshold when 10*I < k*U; a negative union always fails
            if (check_overlap && it.opt >= OPT_TH_FIRST && it.opt <= OPT_TH_LAST) begin
                iw = ((br < cr) ? br : cr) - ((bl > cl) ? bl : cl);
                ih = ((bb < cb) ? bb : cb) - ((bt > ct) ? bt : ct);
                if (iw < 0) iw = 0;
                if (ih < 0) ih = 0;
                inter = iw * ih;
                area_box = (bb - bt) * (br - bl);
                area_crop = (cb - ct) * (cr - cl);
                uni = area_box + area_crop - inter;
                case (it.opt)
                    OPT_IOU_0P1: k = 1;
                    OPT_IOU_0P3: k = 3;
                    OPT_IOU_0P5: k = 5;
                    OPT_IOU_0P7: k = 7;
                    default:     k = 9;
                endcase
                if (uni < 0 || (uni > 0 && 10 * inter < k * uni)) begin
                    overlap_failed = 1;
                end
            end
            // Center strictly inside, compared at doubled scale
            if (bl + br > 2 * cl && bl + br < 2 * cr && bt + bb > 2 * ct && bt + bb < 2 * cb) begin
                if (centre_count < MAX_BOXES) centre_count++;
            end
            if (!it.last) return;
            if (it.opt >= OPT_WHOLE || shape_forced) begin
                v = '{accept: 1, whole: 1, aspect_bad: 0, overlap_bad: 0, centres: '0};
            end else begin
                w = cr - cl;
                h = cb - ct;
                v.whole = 0;
                v.aspect_bad = (w <= 0) || (h <= 0) || (2 * w < h) || (w > 2 * h);
                v.overlap_bad = check_overlap && overlap_failed;
                v.accept = !v.aspect_bad && !v.overlap_bad && centre_count > 0;
                v.centres = CNT_W'(centre_count);
            end
            expected_verdicts.insert(expected_verdicts.size(), v);
        endfunction

        // Compare one verdict from the block with the oldest expected one
        task check_verdict(logic [M_TDATA_W-1:0] d);
            verdict_t want;
            verdict_t got;
            got.accept = d[0];
            got.whole = d[1];
            got.aspect_bad = d[2];
            got.overlap_bad = d[3];
            got.centres = d[4 +: CNT_W];
            if (expected_verdicts.size() == 0) begin
                report($sformatf("verdict %h with none expected", d));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.accept !== want.accept)
                report($sformatf("accept %b, want %b", got.accept, want.accept));
            if (got.whole !== want.whole)
                report($sformatf("whole_image %b, want %b", got.whole, want.whole));
            if (got.aspect_bad !== want.aspect_bad)
                report($sformatf("aspect_bad %b, want %b", got.aspect_bad, want.aspect_bad));
            if (got.overlap_bad !== want.overlap_bad)
                report($sformatf("overlap_bad %b, want %b", got.overlap_bad, want.overlap_bad));
            if (got.centres !== want.centres)
                report($sformatf("centres_inside %0d, want %0d", got.centres, want.centres));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic                   cfg_data = 1'b0;

    crop_verdict_board board;
    box_item_t         seen_box;
    int                tx_idle_pct = 0;
    int                rx_stall_pct = 0;
    int                hold_requests = 0;
    int                hold_served = 0;
    int                hold_left = 0;
    int                sent_count = 0;
    int                cycle_count = 0;

    ssd_crop_candidate_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen_box.cl = s_tdata[CROP_L_LSB +: COORD_W];
                seen_box.ct = s_tdata[CROP_T_LSB +: COORD_W];
                seen_box.cr = s_tdata[CROP_R_LSB +: COORD_W];
                seen_box.cb = s_tdata[CROP_B_LSB +: COORD_W];
                seen_box.opt = s_tdata[OPTION_LSB +: OPT_W];
                seen_box.bl = s_tdata[BOX_LEFT_LSB +: COORD_W];
                seen_box.bt = s_tdata[BOX_TOP_LSB +: COORD_W];
                seen_box.br = s_tdata[BOX_RIGHT_LSB +: COORD_W];
                seen_box.bb = s_tdata[BOX_BOTTOM_LSB +: COORD_W];
                seen_box.first = s_tuser;
                seen_box.last = s_tlast;
                board.predict_box(seen_box);
            end
            if (m_tvalid && m_tready) begin
                board.check_verdict(m_tdata);
            end
        end
    end

    // Drive the receiver: random stalls, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_box(box_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[CROP_L_LSB +: COORD_W] = it.cl;
        d[CROP_T_LSB +: COORD_W] = it.ct;
        d[CROP_R_LSB +: COORD_W] = it.cr;
        d[CROP_B_LSB +: COORD_W] = it.cb;
        d[OPTION_LSB +: OPT_W] = it.opt;
        d[BOX_LEFT_LSB +: COORD_W] = it.bl;
        d[BOX_TOP_LSB +: COORD_W] = it.bt;
        d[BOX_RIGHT_LSB +: COORD_W] = it.br;
        d[BOX_BOTTOM_LSB +: COORD_W] = it.bb;
        return d;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > ONE) ? ONE : v);
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(9))
            0:       return 0;
            1:       return ONE;
            default: return int'($urandom_range(ONE));
        endcase
    endfunction

    function automatic int jitter(int base, int span);
        return clamp_coord(base + int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [OPT_W-1:0] pick_option();
        case ($urandom_range(9))
            0:       return OPT_NONE;
            8:       return OPT_WHOLE;
            9:       return OPT_WHOLE_ALT;
            default: return OPT_W'($urandom_range(OPT_TH_FIRST, OPT_TH_LAST));
        endcase
    endfunction

    // Mostly sane crops with aspect near the limits, some full-image, some arbitrary
    function automatic void make_crop(inout box_item_t it);
        int w, h, l, t;
        case ($urandom_range(9))
            0: begin
                it.cl = COORD_W'(pick_coord());
                it.ct = COORD_W'(pick_coord());
                it.cr = COORD_W'(pick_coord());
                it.cb = COORD_W'(pick_coord());
            end
            1: begin
                it.cl = '0;
                it.ct = '0;
                it.cr = COORD_W'(ONE);
                it.cb = COORD_W'(ONE);
            end
            default: begin
                w = int'($urandom_range(1, ONE));
                case ($urandom_range(3))
                    0:       h = w / 2;
                    1:       h = w * 2;
                    default: h = w / 3 + int'($urandom_range(w * 3 - w / 3));
                endcase
                if (h < 1) h = 1;
                if (h > ONE) h = ONE;
                l = int'($urandom_range(ONE - w));
                t = int'($urandom_range(ONE - h));
                it.cl = COORD_W'(l);
                it.ct = COORD_W'(t);
                it.cr = COORD_W'(l + w);
                it.cb = COORD_W'(t + h);
            end
        endcase
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_box(input box_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= pack_box(it);
        s_tuser <= it.first;
        s_tlast <= it.last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic send_fields(input int cl, ct, cr, cb, input logic [OPT_W-1:0] opt,
                               input int bl, bt, br, bb, input bit first, last);
        box_item_t it;
        it = '{cl: COORD_W'(cl), ct: COORD_W'(ct), cr: COORD_W'(cr), cb: COORD_W'(cb),
               opt: opt, bl: COORD_W'(bl), bt: COORD_W'(bt), br: COORD_W'(br),
               bb: COORD_W'(bb), first: first, last: last};
        send_box(it);
    endtask

    // One image: boxes scattered around the crop at a random scale
    task automatic send_image(input int n_boxes, input bit opens, input bit closes);
        box_item_t it;
        int span, w, i;
        it = '{default: '0};
        make_crop(it);
        it.opt = pick_option();
        w = (it.cr > it.cl) ? int'(it.cr) - int'(it.cl) : 1;
        case ($urandom_range(4))
            0:       span = 0;
            1:       span = w / 64;
            2:       span = w / 8;
            3:       span = w / 2;
            default: span = w;
        endcase
        for (i = 0; i < n_boxes; i++) begin
            if ($urandom_range(19) == 0) begin
                make_crop(it);
                it.opt = pick_option();
            end
            if ($urandom_range(9) == 0) begin
                it.bl = COORD_W'(pick_coord());
                it.bt = COORD_W'(pick_coord());
                it.br = COORD_W'(pick_coord());
                it.bb = COORD_W'(pick_coord());
            end else begin
                it.bl = COORD_W'(jitter(it.cl, span));
                it.bt = COORD_W'(jitter(it.ct, span));
                it.br = COORD_W'(jitter(it.cr, span));
                it.bb = COORD_W'(jitter(it.cb, span));
            end
            it.first = opens && i == 0;
            it.last = closes && i == n_boxes - 1;
            send_box(it);
        end
    endtask

    // Drain all owed verdicts, then let any box still in flight finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic write_regs(input bit overlap_on, input bit shape_on);
        logic [CFG_IDX_W-1:0] idx [2];
        logic                 val [2];
        int i;
        idx[0] = REG_CHECK_ALL_OVERLAP;
        idx[1] = REG_SHAPE_GIVEN;
        val[0] = overlap_on;
        val[1] = shape_on;
        for (i = 0; i < 2; i++) begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            board.set_reg(idx[i], val[i]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_images(input int n_items);
        int stop_at;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            case ($urandom_range(9))
                0:       send_image(int'($urandom_range(1, 4)), 1'b0, 1'b1);
                1:       send_image(int'($urandom_range(1, 4)), 1'b1, 1'b0);
                default: send_image(int'($urandom_range(1, 6)), 1'b1, 1'b1);
            endcase
        end
    endtask

    task automatic run_phase(input bit overlap_on, shape_on, input int tx, rx, n_items);
        settle();
        write_regs(overlap_on, shape_on);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
        random_images(n_items);
    endtask

    initial begin
        int i, bl, bt;
        board = new();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Aspect, degenerate crop, center edge and whole-image cases, overlap check off
        write_regs(1'b0, 1'b0);
        send_fields(0, 0, ONE, ONE, OPT_NONE, 1000, 1000, 2000, 2000, 1, 1);
        send_fields(0, 0, 0, 0, OPT_NONE, 0, 0, ONE, ONE, 1, 1);
        send_fields(40000, 0, 10000, 30000, OPT_NONE, 20000, 5000, 30000, 9000, 1, 1);
        send_fields(0, 0, 40000, 20000, OPT_NONE, 10000, 5000, 20000, 15000, 1, 1);
        send_fields(0, 0, 20000, 40000, OPT_NONE, 5000, 10000, 15000, 20000, 1, 1);
        send_fields(0, 0, 40001, 20000, OPT_NONE, 10000, 5000, 20000, 15000, 1, 1);
        send_fields(0, 0, 20000, 40001, OPT_NONE, 5000, 10000, 15000, 20000, 1, 1);
        send_fields(0, 0, ONE, ONE, OPT_NONE, 0, 0, 0, 0, 1, 1);
        send_fields(0, 0, ONE, ONE, OPT_WHOLE, 0, 0, ONE, ONE, 1, 1);
        send_fields(131071, 0, 0, 0, OPT_WHOLE_ALT, ONE, ONE, 0, 0, 1, 1);
        // Accumulate across items without first_box, and past a last_box
        send_fields(0, 0, ONE, ONE, OPT_NONE, 100, 100, 300, 300, 1, 0);
        send_fields(0, 0, ONE, ONE, OPT_NONE, 500, 500, 900, 900, 0, 0);
        send_fields(0, 0, ONE, ONE, OPT_NONE, 700, 700, 800, 800, 0, 1);
        send_fields(0, 0, ONE, ONE, OPT_NONE, 50, 50, 60, 60, 0, 1);
        settle();

        // Every threshold against a box with IoU of about 0.39, then union edge cases
        write_regs(1'b1, 1'b0);
        for (i = OPT_TH_FIRST; i <= OPT_TH_LAST; i++) begin
            send_fields(0, 0, 32768, 32768, OPT_W'(i), 8192, 8192, 40960, 40960, 1, 1);
        end
        send_fields(10000, 10000, 10000, 10000, OPT_IOU_0P9, 5000, 5000, 5000, 5000, 1, 1);
        send_fields(0, 0, 100, 100, OPT_IOU_0P1, ONE, 0, 0, ONE, 1, 0);
        send_fields(0, 0, 100, 100, OPT_IOU_0P1, 10, 10, 90, 90, 0, 1);
        settle();
        write_regs(1'b1, 1'b1);
        send_fields(0, 0, 40001, 20000, OPT_IOU_0P9, ONE, ONE, 0, 0, 1, 1);

        // Random phase with a long receiver hold, then a crowded image that saturates
        run_phase(1'b0, 1'b0, 0, 0, 0);
        hold_requests++;
        for (i = 0; i < 30; i++) send_image(1, 1'b1, 1'b1);
        settle();
        write_regs(1'b1, 1'b0);
        for (i = 0; i < CROWD_BOXES; i++) begin
            bl = int'($urandom_range(1, 30000));
            bt = int'($urandom_range(1, 30000));
            send_fields(0, 0, ONE, ONE, pick_option() % OPT_WHOLE, bl, bt,
                        bl + int'($urandom_range(1, 30000)), bt + int'($urandom_range(1, 30000)),
                        i == 0, i == CROWD_BOXES - 1);
        end
        random_images(100);

        run_phase(1'b1, 1'b0, IDLE_PCT, 0, 150);
        run_phase(1'b1, 1'b0, 0, IDLE_PCT, 150);
        run_phase(1'b1, 1'b0, BOTH_PCT, BOTH_PCT, 150);
        run_phase(1'b0, 1'b1, 0, 0, 60);
        run_phase(1'b1, 1'b1, IDLE_PCT, IDLE_PCT, 60);
        run_phase(1'b0, 1'b0, 0, 0, 100);
        settle();

        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
